>>> rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared constants and controller/datapath interface types for the sliding
// median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int DATA_W = 16;

    typedef struct packed {
        logic shift;
        logic load_res;
        logic load_out;
        logic out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic rank_hit;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/smf_datapath.sv
// ----------------------------------------------------------------------------
// smf_datapath
// Sample window, rank unit that tests one candidate per cycle, result
// register and output word register.
// ----------------------------------------------------------------------------
module smf_datapath #(
    parameter int HALF_WIDTH = 2,
    localparam int WIN = 2 * HALF_WIDTH + 1,
    localparam int IW  = $clog2(WIN)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic signed [smf_pkg::DATA_W-1:0] i_sample,
    input  smf_pkg::t_dp_cmd               i_cmd,
    input  logic [IW-1:0]                  i_sel,
    output smf_pkg::t_dp_sts               o_sts,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic signed [smf_pkg::DATA_W-1:0] o_out_data,
    output logic                           o_out_last
);

    localparam int CW = $clog2(WIN + 1);

    logic signed [smf_pkg::DATA_W-1:0] r_win [WIN];
    logic signed [smf_pkg::DATA_W-1:0] r_res;
    logic signed [smf_pkg::DATA_W-1:0] w_cand;
    logic [CW-1:0]                     w_rank;
    logic                              r_out_valid;
    logic signed [smf_pkg::DATA_W-1:0] r_out_data;
    logic                              r_out_last;

    assign w_cand = r_win[i_sel];

    always_comb begin
        logic [CW-1:0] n_cnt;
        n_cnt = '0;
        for (int e = 0; e < WIN; e++) begin
            if ((r_win[e] < w_cand) || ((IW'(e) < i_sel) && (r_win[e] == w_cand))) begin
                n_cnt = n_cnt + CW'(1);
            end
        end
        w_rank = n_cnt;
    end

    assign o_sts.rank_hit = (w_rank == CW'(HALF_WIDTH));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            for (int e = 0; e < WIN - 1; e++) begin
                r_win[e] <= r_win[e + 1];
            end
            r_win[WIN-1] <= i_sample;
        end
        if (i_cmd.load_res) begin
            r_res <= w_cand;
        end
        if (i_cmd.load_out) begin
            r_out_data <= r_res;
            r_out_last <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

>>> rtl/smf_ctrl.sv
// ----------------------------------------------------------------------------
// smf_ctrl
// Sequencer: takes a word, decides which positions are due, drives the rank
// scan or raw pick, and hands each result to the output register.
// ----------------------------------------------------------------------------
module smf_ctrl #(
    parameter int HALF_WIDTH = 2,
    localparam int WIN = 2 * HALF_WIDTH + 1,
    localparam int IW  = $clog2(WIN)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    output smf_pkg::t_dp_cmd o_cmd,
    output logic [IW-1:0]    o_sel,
    input  smf_pkg::t_dp_sts i_sts
);

    localparam int SW = $clog2(2 * HALF_WIDTH + 1);
    localparam int JW = $clog2(HALF_WIDTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PICK = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [SW-1:0] K_H      = SW'(HALF_WIDTH);
    localparam logic [SW-1:0] K_2H     = SW'(2 * HALF_WIDTH);
    localparam logic [JW-1:0] J_H      = JW'(HALF_WIDTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(WIN - 1);

    logic [1:0]    r_state, n_state;
    logic [SW-1:0] r_seen,  n_seen;
    logic [SW-1:0] r_k,     n_k;
    logic          r_end,   n_end;
    logic [JW-1:0] r_j,     n_j;
    logic [IW-1:0] r_cand,  n_cand;
    logic          w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_sel      = (r_state == S_SCAN) ? r_cand : (LAST_IDX - IW'(r_j));

    always_comb begin
        n_state = r_state;
        n_seen  = r_seen;
        n_k     = r_k;
        n_end   = r_end;
        n_j     = r_j;
        n_cand  = r_cand;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.shift = 1'b1;
                    n_k   = r_seen;
                    n_end = i_in_last;
                    if (i_in_last) begin
                        n_seen = '0;
                        n_j    = (r_seen < K_H) ? JW'(r_seen) : J_H;
                    end else begin
                        n_j = J_H;
                        if (r_seen < K_2H) begin
                            n_seen = r_seen + SW'(1);
                        end
                    end
                    if (i_in_last || (r_seen >= K_H)) begin
                        n_state = S_PICK;
                    end
                end
            end
            S_PICK: begin
                if ((r_j == J_H) && (r_k >= K_2H)) begin
                    n_cand  = '0;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.load_res = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_SCAN: begin
                if (i_sts.rank_hit) begin
                    o_cmd.load_res = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    n_cand = r_cand + IW'(1);
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_last = r_end && (r_j == '0);
                    if (r_end && (r_j != '0)) begin
                        n_j     = r_j - JW'(1);
                        n_state = S_PICK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seen  <= '0;
            r_k     <= '0;
            r_end   <= 1'b0;
            r_j     <= '0;
            r_cand  <= '0;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
            r_k     <= n_k;
            r_end   <= n_end;
            r_j     <= n_j;
            r_cand  <= n_cand;
        end
    end

endmodule

>>> rtl/sliding_median_filter.sv
// ----------------------------------------------------------------------------
// sliding_median_filter
// Median filter over a window of 2*HALF_WIDTH+1 signed 16-bit samples.
//
// Input words carry one sample on s_axis_tdata, s_axis_tlast marks the last
// sample of a signal. Output words carry the filtered sample, with
// m_axis_tlast on the last position of the signal. Positions leave
// HALF_WIDTH words late; the first and last HALF_WIDTH positions pass raw,
// the rest carry the window median. A tlast word flushes up to
// HALF_WIDTH+1 positions.
// One word is processed at a time. A raw position passes from acceptance
// through the pick state and the result register to the output register;
// a median position adds up to one rank test per window entry, run by the
// single rank unit that walks the window. s_axis_tready is high only while
// idle; an item with no due position leaves the sequencer idle.
// A one-word output register holds a result while m_axis_tready is low and
// stalls the sequencer until it is taken. Reset empties the output register
// and starts a new signal; window contents are not cleared.
// ----------------------------------------------------------------------------
module sliding_median_filter #(
    parameter int HALF_WIDTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] filtered
    output logic        m_axis_tlast
);

    localparam int WIN = 2 * HALF_WIDTH + 1;
    localparam int IW  = $clog2(WIN);

    smf_pkg::t_dp_cmd                     cmd;
    smf_pkg::t_dp_sts                     sts;
    logic [IW-1:0]                        sel;
    logic signed [smf_pkg::DATA_W-1:0]    out_data;

    smf_ctrl #(
        .HALF_WIDTH (HALF_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .o_sel      (sel),
        .i_sts      (sts)
    );

    smf_datapath #(
        .HALF_WIDTH (HALF_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (s_axis_tdata),
        .i_cmd       (cmd),
        .i_sel       (sel),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (out_data),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = out_data;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("output register overwritten while occupied");

    a_shift_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.shift |-> (!cmd.load_res && !cmd.load_out))
        else $error("window shift overlaps result handling");

    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sel <= IW'(WIN - 1))
        else $error("window select out of range");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("end of signal accepted without flush");
`endif

endmodule

>>> verif/tb_sliding_median_filter.sv
// ----------------------------------------------------------------------------
// tb_sliding_median_filter
// Self-checking bench for the sliding median filter. Signals of random length
// and content stream in while both ends of the block stall at random. A
// scoreboard keeps its own window and signal position, predicts every output
// word and compares it with what the block emits.
// ----------------------------------------------------------------------------
module tb_sliding_median_filter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W = smf_pkg::DATA_W;

    localparam int HALF_W = 2;

    class median_scoreboard;
        localparam int HALF = HALF_W;
        localparam int TAPS = 2 * HALF + 1;

        typedef struct packed {
            logic signed [DATA_W-1:0] filtered;
            logic                     final_res;
        } t_filt_word;

        logic signed [DATA_W-1:0] taps [TAPS];
        int                       depth_seen;
        t_filt_word               expected_q [$];
        int                       errors;

        function new();
            depth_seen = 0;
            errors     = 0;
        endfunction

        function logic signed [DATA_W-1:0] taps_median();
            logic signed [DATA_W-1:0] s [TAPS];
            logic signed [DATA_W-1:0] v;
            int                       b;
            for (int a = 0; a < TAPS; a++) begin
                v = taps[a];
                b = a;
                while (b > 0 && s[b-1] > v) begin
                    s[b] = s[b-1];
                    b--;
                end
                s[b] = v;
            end
            return s[HALF];
        endfunction

        function void add_expected(logic signed [DATA_W-1:0] val, logic last);
            t_filt_word w;
            w.filtered  = val;
            w.final_res = last;
            expected_q.insert(expected_q.size(), w);
        endfunction

        function void note_sample(logic signed [DATA_W-1:0] smp, logic last);
            int                       k;
            int                       j;
            logic signed [DATA_W-1:0] mid;
            k = depth_seen;
            for (int a = 0; a < TAPS - 1; a++)
                taps[a] = taps[a+1];
            taps[TAPS-1] = smp;
            if (k >= 2 * HALF)
                mid = taps_median();
            if (!last) begin
                if (k >= HALF)
                    add_expected((k >= 2 * HALF) ? mid : taps[TAPS-1-HALF], 1'b0);
                if (k < 2 * HALF)
                    depth_seen = k + 1;
            end else begin
                for (j = (k < HALF) ? k : HALF; j >= 0; j--) begin
                    if (j == HALF && k >= 2 * HALF)
                        add_expected(mid, j == 0);
                    else
                        add_expected(taps[TAPS-1-j], j == 0);
                end
                depth_seen = 0;
            end
        endfunction

        function void check_word(logic signed [DATA_W-1:0] filt, logic last);
            t_filt_word want;
            if (expected_q.size() == 0) begin
                $error("unexpected word: filtered %0d, final_res %0b", filt, last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (filt !== want.filtered) begin
                $error("filtered: expected %0d, actual %0d", want.filtered, filt);
                errors++;
            end
            if (last !== want.final_res) begin
                $error("final_res: expected %0b, actual %0b", want.final_res, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;

    median_scoreboard           sb;
    bit                         quiet = 1'b0;
    int                         words_sent = 0;

    always #10 i_clk = ~i_clk;

    sliding_median_filter #(
        .HALF_WIDTH (HALF_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_sample(s_axis_tdata, s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 26);
    end

    task automatic send_word(input logic [DATA_W-1:0] smp, input logic last);
        while (!quiet && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_signal(input int len);
        int                mode;
        logic [DATA_W-1:0] smp;
        mode = $urandom_range(3);
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: smp = DATA_W'($urandom());
                1: smp = DATA_W'($urandom_range(8)) - DATA_W'(4);
                2: begin
                    case ($urandom_range(4))
                        0: smp = 16'h7FFF;
                        1: smp = 16'h8000;
                        2: smp = 16'h0000;
                        3: smp = 16'hFFFF;
                        default: smp = 16'h0001;
                    endcase
                end
                default: smp = ($urandom_range(1) ? 16'h7FF0 : 16'h8000)
                               + DATA_W'($urandom_range(15));
            endcase
            send_word(smp, i == len - 1);
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // {sample, last}: signals of length 1 through 5, then one of 7
    logic [DATA_W:0] directed [22] = '{
        {16'h7FFF, 1'b1},
        {16'h8000, 1'b0}, {16'h7FFF, 1'b1},
        {16'h0000, 1'b0}, {16'hFFFF, 1'b0}, {16'h0001, 1'b1},
        {16'h8000, 1'b0}, {16'h8000, 1'b0}, {16'h7FFF, 1'b0}, {16'h5555, 1'b1},
        {16'h7FFF, 1'b0}, {16'h8000, 1'b0}, {16'h0000, 1'b0}, {16'hFFFF, 1'b0},
        {16'h0001, 1'b1},
        {16'h7FFF, 1'b0}, {16'h7FFF, 1'b0}, {16'h8000, 1'b0}, {16'h8000, 1'b0},
        {16'h7FFF, 1'b0}, {16'hFFFF, 1'b0}, {16'hAAAA, 1'b1}
    };

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (directed[i])
            send_word(directed[i][DATA_W:1], directed[i][0]);
        wait_drain();

        while (words_sent < 170)
            send_signal(($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40));
        quiet = 1'b1;
        while (words_sent < 290)
            send_signal(($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40));
        quiet = 1'b0;
        wait_drain();
        while (words_sent < 445)
            send_signal(($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40));

        wait_drain();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** sliding_median_filter: PASSED **");
        end else begin
            $display("** sliding_median_filter: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("** sliding_median_filter: FAILED **");
        $finish;
    end

endmodule

>>> files.f
rtl/smf_pkg.sv
rtl/smf_datapath.sv
rtl/smf_ctrl.sv
rtl/sliding_median_filter.sv
verif/tb_sliding_median_filter.sv
